// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL. Defining NO_ASSERTIONS
// removes every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hw/rtl/l4hfx_pkg.sv
// ----------------------------------------------------------------------------
// l4hfx_pkg
// Types and constants of the IPv4 and transport header field extractor.
// ----------------------------------------------------------------------------
package l4hfx_pkg;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [5:0] LINK_BYTES_RESET = 6'd14;
	localparam logic [3:0] IHL_MIN          = 4'd5;
	localparam logic [7:0] IP_HDR_BYTES     = 8'd20;
	localparam logic [7:0] POS_MAX          = 8'd255;
	localparam logic [7:0] PROTO_TCP        = 8'd6;
	localparam logic [7:0] PROTO_UDP        = 8'd17;
	localparam logic [7:0] PROTO_ICMP       = 8'd1;

	typedef enum logic [4:0] {
		FID_VERSION    = 5'd0,
		FID_IHL        = 5'd1,
		FID_TOTLEN     = 5'd2,
		FID_IDENT      = 5'd3,
		FID_FLAGS      = 5'd4,
		FID_FRAGOFF    = 5'd5,
		FID_TTL        = 5'd6,
		FID_PROTO      = 5'd7,
		FID_IPCSUM     = 5'd8,
		FID_SRC        = 5'd9,
		FID_DST        = 5'd10,
		FID_TCP_SPORT  = 5'd11,
		FID_TCP_DPORT  = 5'd12,
		FID_TCP_SEQ    = 5'd13,
		FID_TCP_ACK    = 5'd14,
		FID_TCP_HLEN   = 5'd15,
		FID_TCP_WINDOW = 5'd16,
		FID_UDP_SPORT  = 5'd17,
		FID_UDP_DPORT  = 5'd18,
		FID_UDP_LEN    = 5'd19,
		FID_UDP_CSUM   = 5'd20,
		FID_ICMP_TYPE  = 5'd21,
		FID_ICMP_CODE  = 5'd22,
		FID_ICMP_CSUM  = 5'd23
	} field_id_t;

	typedef struct packed {
		field_id_t   id;
		logic [31:0] value;
	} result_t;

	typedef struct packed {
		result_t r0;
		result_t r1;
		logic    two;
	} pair_t;

	typedef struct packed {
		logic [7:0]  frame_byte;
		logic [31:0] shift;
		logic        in_ip;
		logic [7:0]  ip_off;
		logic [3:0]  ihl;
		logic [7:0]  kind;
	} front_t;

	typedef struct packed {
		logic [FIFO_AW:0] cnt;
		logic             empty;
	} fifo_stat_t;

endpackage

// File: hw/rtl/l4hfx_front.sv
// ----------------------------------------------------------------------------
// l4hfx_front
// Frame position tracking, shift register, latched header length and
// protocol, and the stage-one register that feeds field decoding.
// ----------------------------------------------------------------------------
module l4hfx_front import l4hfx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [5:0] cfg_data,
	input  logic       accept,
	input  logic [7:0] frame_byte,
	input  logic       frame_end,
	output front_t     front_s1,
	output logic       valid_s1
);

	logic [5:0]  link_q;
	logic [7:0]  pos_q;
	logic [31:0] shift_q;
	logic [3:0]  ihl_q;
	logic [7:0]  kind_q;
	logic        in_ip;
	logic [7:0]  ip_off;
	logic [31:0] shift_next;

	assign in_ip      = pos_q >= {2'b00, link_q};
	assign ip_off     = pos_q - {2'b00, link_q};
	assign shift_next = {shift_q[23:0], frame_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q   <= LINK_BYTES_RESET;
			pos_q    <= '0;
			shift_q  <= '0;
			ihl_q    <= '0;
			kind_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (cfg_we) begin
				link_q <= cfg_data;
			end
			if (accept) begin
				if (frame_end) begin
					pos_q   <= '0;
					shift_q <= '0;
					ihl_q   <= '0;
					kind_q  <= '0;
				end else begin
					shift_q <= shift_next;
					if (pos_q != POS_MAX) begin
						pos_q <= pos_q + 8'd1;
					end
					if (in_ip && ip_off == 8'd0) begin
						ihl_q <= frame_byte[3:0];
					end
					if (in_ip && ip_off == 8'd9) begin
						kind_q <= frame_byte;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			front_s1.frame_byte <= frame_byte;
			front_s1.shift      <= shift_next;
			front_s1.in_ip      <= in_ip;
			front_s1.ip_off     <= ip_off;
			front_s1.ihl        <= ihl_q;
			front_s1.kind       <= kind_q;
		end
	end

endmodule

// File: hw/rtl/l4hfx_decode.sv
// ----------------------------------------------------------------------------
// l4hfx_decode
// Turns one registered byte and its header offset into zero, one or two
// completed header fields.
// ----------------------------------------------------------------------------
module l4hfx_decode import l4hfx_pkg::*; (
	input  front_t front_s1,
	output pair_t  pair,
	output logic   has
);

	logic [7:0]  b;
	logic [31:0] sh;
	logic [7:0]  start;
	logic [7:0]  t_off;

	function automatic result_t mk(field_id_t id, logic [31:0] v);
		result_t r;
		r.id    = id;
		r.value = v;
		return r;
	endfunction

	assign b     = front_s1.frame_byte;
	assign sh    = front_s1.shift;
	assign start = {2'b00, front_s1.ihl, 2'b00};
	assign t_off = front_s1.ip_off - start;

	always_comb begin
		pair = '0;
		has  = 1'b1;
		if (front_s1.in_ip && front_s1.ip_off < IP_HDR_BYTES) begin
			unique case (front_s1.ip_off[4:0])
				5'd0: begin
					pair.r0  = mk(FID_VERSION, {28'd0, b[7:4]});
					pair.r1  = mk(FID_IHL, {28'd0, b[3:0]});
					pair.two = 1'b1;
				end
				5'd3:  pair.r0 = mk(FID_TOTLEN, {16'd0, sh[15:0]});
				5'd5:  pair.r0 = mk(FID_IDENT, {16'd0, sh[15:0]});
				5'd6:  pair.r0 = mk(FID_FLAGS, {29'd0, b[7:5]});
				5'd7:  pair.r0 = mk(FID_FRAGOFF, {19'd0, sh[12:0]});
				5'd8:  pair.r0 = mk(FID_TTL, {24'd0, b});
				5'd9:  pair.r0 = mk(FID_PROTO, {24'd0, b});
				5'd11: pair.r0 = mk(FID_IPCSUM, {16'd0, sh[15:0]});
				5'd15: pair.r0 = mk(FID_SRC, sh);
				5'd19: pair.r0 = mk(FID_DST, sh);
				default: has = 1'b0;
			endcase
		end else if (front_s1.in_ip && front_s1.ihl >= IHL_MIN && front_s1.ip_off >= start) begin
			priority if (front_s1.kind == PROTO_TCP) begin
				unique case (t_off)
					8'd1:  pair.r0 = mk(FID_TCP_SPORT, {16'd0, sh[15:0]});
					8'd3:  pair.r0 = mk(FID_TCP_DPORT, {16'd0, sh[15:0]});
					8'd7:  pair.r0 = mk(FID_TCP_SEQ, sh);
					8'd11: pair.r0 = mk(FID_TCP_ACK, sh);
					8'd12: pair.r0 = mk(FID_TCP_HLEN, {28'd0, b[7:4]});
					8'd15: pair.r0 = mk(FID_TCP_WINDOW, {16'd0, sh[15:0]});
					default: has = 1'b0;
				endcase
			end else if (front_s1.kind == PROTO_UDP) begin
				unique case (t_off)
					8'd1: pair.r0 = mk(FID_UDP_SPORT, {16'd0, sh[15:0]});
					8'd3: pair.r0 = mk(FID_UDP_DPORT, {16'd0, sh[15:0]});
					8'd5: pair.r0 = mk(FID_UDP_LEN, {16'd0, sh[15:0]});
					8'd7: pair.r0 = mk(FID_UDP_CSUM, {16'd0, sh[15:0]});
					default: has = 1'b0;
				endcase
			end else if (front_s1.kind == PROTO_ICMP) begin
				unique case (t_off)
					8'd0: pair.r0 = mk(FID_ICMP_TYPE, {24'd0, b});
					8'd1: pair.r0 = mk(FID_ICMP_CODE, {24'd0, b});
					8'd3: pair.r0 = mk(FID_ICMP_CSUM, {16'd0, sh[15:0]});
					default: has = 1'b0;
				endcase
			end else begin
				has = 1'b0;
			end
		end else begin
			has = 1'b0;
		end
	end

endmodule

// File: hw/rtl/l4hfx_fifo.sv
// ----------------------------------------------------------------------------
// l4hfx_fifo
// Small queue of decoded field pairs between the decoder and the output
// channel.
// ----------------------------------------------------------------------------
module l4hfx_fifo import l4hfx_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  pair_t      wdata,
	input  logic       pop,
	output pair_t      rdata,
	output fifo_stat_t stat
);

	pair_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= FIFO_AW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= FIFO_AW'(rd_ptr_q + 1'b1);
			end
			if (push && !pop) begin
				cnt_q <= (FIFO_AW+1)'(cnt_q + 1'b1);
			end else if (pop && !push) begin
				cnt_q <= (FIFO_AW+1)'(cnt_q - 1'b1);
			end
		end
	end

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.cnt   = cnt_q;
	assign stat.empty = cnt_q == '0;

endmodule

// File: hw/rtl/ipv4_l4_header_field_extractor.sv
// ----------------------------------------------------------------------------
// ipv4_l4_header_field_extractor
// Frame bytes come in on the input channel (in_valid, in_stall, frame_byte,
// frame_end) and completed IPv4, TCP, UDP and ICMP header fields leave on
// the output channel (out_valid, out_stall, field_id, field_value, run_last).
// The link header length is set through cfg_we and cfg_data; the user must
// write it only while idle, as the block itself does not enforce this. A
// byte is registered, decoded in the next cycle and queued. One byte is taken
// every cycle while in_stall is low; the first IPv4 header byte yields two
// words, which leave in order through a four-entry queue of field pairs.
// in_stall rises only when that queue and the decode stage could not hold
// the results of one more byte, so it follows a stalled output channel.
// Reset clears the position, shift register, latched header fields and
// queue, and sets the link header length to fourteen bytes.
// run_last marks the final word that one byte produced.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4_l4_header_field_extractor import l4hfx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  frame_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  field_id,
	output logic [31:0] field_value,
	output logic        run_last
);

	front_t     front_s1;
	logic       valid_s1;
	pair_t      dec_pair;
	logic       dec_has;
	pair_t      head;
	fifo_stat_t fstat;
	logic       push;
	logic       pop;
	logic       in_accept;
	logic       out_accept;
	logic       sub_q;
	result_t    cur;

	assign in_stall   = ({1'b0, fstat.cnt} + (FIFO_AW+2)'(valid_s1))
		> (FIFO_AW+2)'(FIFO_DEPTH - 1);
	assign in_accept  = in_valid && !in_stall;
	assign push       = valid_s1 && dec_has;
	assign out_valid  = !fstat.empty;
	assign out_accept = out_valid && !out_stall;
	assign cur        = sub_q ? head.r1 : head.r0;
	assign field_id   = cur.id;
	assign field_value = cur.value;
	assign run_last   = sub_q || !head.two;
	assign pop        = out_accept && run_last;

	l4hfx_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.accept     (in_accept),
		.frame_byte (frame_byte),
		.frame_end  (frame_end),
		.front_s1   (front_s1),
		.valid_s1   (valid_s1)
	);

	l4hfx_decode u_decode (
		.front_s1 (front_s1),
		.pair     (dec_pair),
		.has      (dec_has)
	);

	l4hfx_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (dec_pair),
		.pop    (pop),
		.rdata  (head),
		.stat   (fstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
		end else if (out_accept) begin
			sub_q <= !run_last;
		end
	end

	`ASSERT_IMPL(a_no_overflow, clk, arst_n, push && !pop, fstat.cnt < (FIFO_AW+1)'(FIFO_DEPTH), "field queue overflow")
	`ASSERT_IMPL(a_first_of_two, clk, arst_n, out_valid && !run_last, field_id == FID_VERSION, "only the version word is followed by another")
	`ASSERT_NEXT(a_ihl_follows, clk, arst_n, out_accept && !run_last, out_valid && run_last && field_id == FID_IHL, "header length word must follow the version word")

endmodule
